FILE: hw/rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// shared types, constants and round functions of the sha-1 stream hasher
// ----------------------------------------------------------------------------
package sha1sh_pkg;

	localparam int NUM_WORDS   = 5;
	localparam int BLOCK_WORDS = 16;
	localparam int NUM_ROUNDS  = 80;
	localparam int H_AW        = $clog2(NUM_WORDS);
	localparam int W_AW        = $clog2(BLOCK_WORDS);
	localparam int RND_W       = $clog2(NUM_ROUNDS);

	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  POS_MASK = 6'h3F;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// working variables a to e
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	function automatic logic [31:0] init_word(input logic [H_AW-1:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = 32'h67452301;
			3'd1:    v = 32'hEFCDAB89;
			3'd2:    v = 32'h98BADCFE;
			3'd3:    v = 32'h10325476;
			3'd4:    v = 32'hC3D2E1F0;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [RND_W-1:0] rnd);
		logic [31:0] k;
		if (rnd < RND_W'(20))      k = K0;
		else if (rnd < RND_W'(40)) k = K1;
		else if (rnd < RND_W'(60)) k = K2;
		else                       k = K3;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [RND_W-1:0] rnd,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < RND_W'(20))      f = (b & c) | (~b & d);
		else if (rnd < RND_W'(40)) f = b ^ c ^ d;
		else if (rnd < RND_W'(60)) f = (b & c) | (b & d) | (c & d);
		else                       f = b ^ c ^ d;
		return f;
	endfunction

endpackage

FILE: hw/rtl/sha1sh_if.sv
// ----------------------------------------------------------------------------
// sha1sh channel interfaces
// message byte channel and digest word channel, valid/ready
// ----------------------------------------------------------------------------
interface sha1sh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;

	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha1sh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hw/rtl/sha1sh_ram.sv
// ----------------------------------------------------------------------------
// sha1sh_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module sha1sh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/sha1sh_round.sv
// ----------------------------------------------------------------------------
// sha1sh_round
// one sha-1 compression round on the working variables
// ----------------------------------------------------------------------------
module sha1sh_round (
	input  sha1sh_pkg::work_t                 cur,
	input  logic [31:0]                       w,
	input  logic [sha1sh_pkg::RND_W-1:0]      rnd,
	output sha1sh_pkg::work_t                 nxt
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		f = sha1sh_pkg::round_f(rnd, cur.b, cur.c, cur.d);
		k = sha1sh_pkg::round_k(rnd);
		t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

FILE: hw/rtl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// byte-serial sha-1 hasher, five digest word beats per closed message
// ----------------------------------------------------------------------------
// A message is fed one byte per beat on msg; a beat with last high closes it
// (with or without a byte of its own) and the 160-bit digest follows on digest
// as five 32-bit beats, word 0 first, last_word on word 4. Each full 64-byte
// block then holds msg.ready low while the chaining words load from their
// ram, the 80 rounds run through the single round unit and the read-add-write
// back completes. Closing writes the padded words one per cycle (up to 16),
// compresses once or, when fewer than 9 bytes of the block are free, twice,
// and each digest word is then read out of the chaining ram. After reset
// no clearing pass is needed: the chaining words read as their initial
// values until written.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	sha1sh_in_if.sink           msg,
	sha1sh_out_if.source        digest
);

	localparam int HAW = sha1sh_pkg::H_AW;
	localparam int WAW = sha1sh_pkg::W_AW;
	localparam int RW  = sha1sh_pkg::RND_W;
	localparam int NW  = sha1sh_pkg::NUM_WORDS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FINAL, ST_EM_RD, ST_EM_CAP
	} state_t;

	state_t           state_q;
	logic [2:0]       cnt_q;      // load / write-back step
	logic [RW-1:0]    rnd_q;
	logic [WAW-1:0]   pw_q;       // pad write pointer
	logic [HAW-1:0]   oi_q;       // digest word pointer
	logic [63:0]      count_q;    // message bytes taken
	logic [23:0]      wacc_q;     // bytes of the word being assembled
	logic             close_pend_q;
	logic             in_pad_q;
	logic             pass2_q;
	logic [NW-1:0]    h_valid_q;
	logic [HAW-1:0]   h_raddr_s1;

	sha1sh_pkg::work_t st_q;
	sha1sh_pkg::work_t st_nxt;
	logic [31:0]      sched_q [sha1sh_pkg::BLOCK_WORDS];

	logic             out_valid_q;
	logic [31:0]      out_word_q;
	logic [2:0]       out_idx_q;
	logic             out_last_q;

	// ram ports
	logic             w_we;
	logic [WAW-1:0]   w_waddr;
	logic [31:0]      w_wdata;
	logic [WAW-1:0]   w_raddr;
	logic [31:0]      w_rdata;
	logic             h_we;
	logic [HAW-1:0]   h_waddr;
	logic [31:0]      h_wdata;
	logic [HAW-1:0]   h_raddr;
	logic [31:0]      h_rdata;

	logic             accept;
	logic [5:0]       byte_pos;
	logic [63:0]      next_count;
	logic [63:0]      bit_len;
	logic             extra;      // length field does not fit this block
	logic [31:0]      pad_word;
	logic [31:0]      pad_data;
	logic [31:0]      h_word;
	logic [31:0]      w_cur;
	logic [31:0]      w_mix;
	logic             out_load;
	logic             last_step;

	assign accept     = msg.valid && msg.ready;
	assign byte_pos   = count_q[5:0] & sha1sh_pkg::POS_MASK;
	assign next_count = count_q + {63'd0, msg.byte_valid};
	assign bit_len    = {count_q[60:0], 3'b000};
	assign extra      = byte_pos >= 6'd56;
	assign last_step  = cnt_q == 3'd5;

	// word holding the 0x80 marker, earlier bytes from the assembly register
	always_comb begin
		case (count_q[1:0])
			2'd0:    pad_word = {sha1sh_pkg::PAD_BYTE, 24'd0};
			2'd1:    pad_word = {wacc_q[7:0], sha1sh_pkg::PAD_BYTE, 16'd0};
			2'd2:    pad_word = {wacc_q[15:0], sha1sh_pkg::PAD_BYTE, 8'd0};
			default: pad_word = {wacc_q[23:0], sha1sh_pkg::PAD_BYTE};
		endcase
	end

	always_comb begin
		if (!pass2_q && pw_q == count_q[5:2]) begin
			pad_data = pad_word;
		end else if (pw_q >= WAW'(14) && (pass2_q || !extra)) begin
			pad_data = pw_q[0] ? bit_len[31:0] : bit_len[63:32];
		end else begin
			pad_data = 32'd0;
		end
	end

	// chaining words read as initial values until first written back
	assign h_word = h_valid_q[h_raddr_s1] ? h_rdata : sha1sh_pkg::init_word(h_raddr_s1);

	// message schedule: ram words for rounds 0..15, rolling taps after
	assign w_mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_cur = (rnd_q < RW'(16)) ? w_rdata : {w_mix[30:0], w_mix[31]};

	always_comb begin
		w_we    = 1'b0;
		w_waddr = pw_q;
		w_wdata = pad_data;
		w_raddr = '0;
		h_we    = 1'b0;
		h_waddr = cnt_q - 3'd1;
		h_wdata = h_word + st_q.a;
		h_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && msg.byte_valid && byte_pos[1:0] == 2'd3) begin
					w_we    = 1'b1;
					w_waddr = byte_pos[5:2];
					w_wdata = {wacc_q, msg.data_byte};
				end
			end
			ST_PAD: begin
				w_we = 1'b1;
			end
			ST_LOAD: begin
				h_raddr = (cnt_q < 3'd5) ? cnt_q : '0;
			end
			ST_ROUND: begin
				w_raddr = rnd_q[WAW-1:0] + WAW'(1);
			end
			ST_FINAL: begin
				h_raddr = (cnt_q < 3'd5) ? cnt_q : '0;
				h_we    = cnt_q != 3'd0;
			end
			ST_EM_RD, ST_EM_CAP: begin
				h_raddr = oi_q;
			end
			default: begin
			end
		endcase
	end

	sha1sh_ram #(
		.WIDTH (32),
		.DEPTH (sha1sh_pkg::BLOCK_WORDS)
	) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	sha1sh_ram #(
		.WIDTH (32),
		.DEPTH (sha1sh_pkg::NUM_WORDS)
	) u_hram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	sha1sh_round u_round (
		.cur (st_q),
		.w   (w_cur),
		.rnd (rnd_q),
		.nxt (st_nxt)
	);

	assign out_load = state_q == ST_EM_CAP && (!out_valid_q || digest.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rnd_q        <= '0;
			pw_q         <= '0;
			oi_q         <= '0;
			count_q      <= '0;
			close_pend_q <= 1'b0;
			in_pad_q     <= 1'b0;
			pass2_q      <= 1'b0;
			h_valid_q    <= '0;
			h_raddr_s1   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			h_raddr_s1 <= h_raddr;
			// output register: a new word may replace the one taken this cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (digest.valid && digest.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= next_count;
						if (msg.byte_valid && byte_pos == 6'd63) begin
							state_q      <= ST_LOAD;
							cnt_q        <= '0;
							close_pend_q <= msg.last;
							in_pad_q     <= 1'b0;
						end else if (msg.last) begin
							state_q  <= ST_PAD;
							in_pad_q <= 1'b1;
							pass2_q  <= 1'b0;
							pw_q     <= next_count[5:2];
						end
					end
				end
				ST_PAD: begin
					pw_q <= pw_q + WAW'(1);
					if (pw_q == WAW'(15)) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 3'd1;
					if (last_step) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + RW'(1);
					if (rnd_q == RW'(sha1sh_pkg::NUM_ROUNDS - 1)) begin
						state_q <= ST_FINAL;
						cnt_q   <= '0;
					end
				end
				ST_FINAL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q != 3'd0) begin
						h_valid_q[h_waddr] <= 1'b1;
					end
					if (last_step) begin
						if (!in_pad_q) begin
							// block filled by data; close now if that beat was last
							if (close_pend_q) begin
								state_q  <= ST_PAD;
								in_pad_q <= 1'b1;
								pass2_q  <= 1'b0;
								pw_q     <= count_q[5:2];
							end else begin
								state_q <= ST_IDLE;
							end
						end else if (!pass2_q && extra) begin
							// length spills into a second padding block
							state_q <= ST_PAD;
							pass2_q <= 1'b1;
							pw_q    <= '0;
						end else begin
							state_q <= ST_EM_RD;
							oi_q    <= '0;
						end
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_CAP;
				end
				ST_EM_CAP: begin
					if (out_load) begin
						if (oi_q == HAW'(NW - 1)) begin
							// digest handed off, back to a fresh message
							state_q      <= ST_IDLE;
							oi_q         <= '0;
							count_q      <= '0;
							h_valid_q    <= '0;
							close_pend_q <= 1'b0;
							in_pad_q     <= 1'b0;
							pass2_q      <= 1'b0;
						end else begin
							oi_q    <= oi_q + HAW'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && msg.byte_valid) begin
			wacc_q <= {wacc_q[15:0], msg.data_byte};
		end
		case (state_q)
			ST_LOAD: begin
				if (cnt_q != 3'd0) begin
					st_q <= {st_q.b, st_q.c, st_q.d, st_q.e, h_word};
				end
			end
			ST_ROUND: begin
				st_q <= st_nxt;
				for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
					sched_q[i] <= sched_q[i+1];
				end
				sched_q[sha1sh_pkg::BLOCK_WORDS-1] <= w_cur;
			end
			ST_FINAL: begin
				if (cnt_q != 3'd0) begin
					st_q <= {st_q.b, st_q.c, st_q.d, st_q.e, st_q.e};
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_word_q <= h_word;
			out_idx_q  <= 3'(oi_q);
			out_last_q <= oi_q == HAW'(NW - 1);
		end
	end

	assign msg.ready          = state_q == ST_IDLE;
	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

	// no message beat is taken while a digest word other than the last is pending
	a_no_take_mid_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && !digest.last_word |-> !msg.ready)
		else $error("message beat taken while digest incomplete");

	// write-back never hits the word being read
	a_hram_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		h_we |-> h_waddr != h_raddr)
		else $error("chaining ram read and write at one address");

	// block words hold still while a compression runs
	a_wram_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_ROUND || state_q == ST_FINAL) |-> !w_we)
		else $error("block ram written during compression");

	// last_word flags exactly word four
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> digest.last_word == (digest.word_index == 3'd4))
		else $error("last_word and word_index disagree");

	// a new digest word only follows a taken one
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && !digest.ready |=> digest.valid && $stable(digest.word_index))
		else $error("digest beat dropped while stalled");

endmodule

FILE: tb/sha1_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// self-checking bench: message bytes in, digest word beats checked against a
// sha-1 predictor of its own, with bursty sending and a stalling receiver
// ----------------------------------------------------------------------------
// A short table of directed beats goes first: idle beats, the empty message,
// single bytes at the extremes, a byte carrying last, a closing-only beat after
// bytes and a repeated close. Rows whose digest is well known carry it typed
// in; the rest are predicted. Random messages follow, most of them short, some
// around the padding boundaries of one block and a few spanning two blocks or
// more, with stray idle beats mixed in and both ways of closing.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;

	localparam int RANDOM_ITEMS = 350;
	// longest quiet spell of a correct run is a two-block close plus a held
	// receiver, far below this limit
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] A_DIGEST     = 160'h86f7e437_faa5a7fc_e15d1ddc_b9eaeaea_377667b8;
	localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	localparam logic [31:0] H_INIT [sha1sh_pkg::NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         bv;
		logic         lst;
		logic         known;
		logic [159:0] digest;
	} stim_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	// directed beats: data, byte_valid, last, digest typed in, digest
	localparam int DIR_ROWS = 17;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},        // idle straight after reset
		'{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
		'{8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST},      // lone byte carrying last
		'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},        // idle in mid message
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},        // zero byte alone
		'{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},        // all-ones byte alone
		'{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h7F, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},        // closing-only after bytes
		'{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'hFE, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},        // close, data ignored
		'{8'h3C, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // back-to-back close
		'{8'hC3, 1'b0, 1'b0, 1'b0, 160'h0}
	};

	logic clk;
	logic arst_n;

	sha1sh_in_if  msg_ch ();
	sha1sh_out_if dig_ch ();

	sha1_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	// predictor state
	logic [31:0] chain_h [sha1sh_pkg::NUM_WORDS];
	logic [7:0]  blk_buf [64];
	logic [63:0] msg_len;

	digest_beat_t expected_digest_q [$];

	int mismatch_count = 0;
	int words_checked  = 0;
	int items_sent     = 0;
	int n_messages     = 0;
	int n_bytes        = 0;
	int longest_msg    = 0;
	int burst_left     = 0;
	int quiet_cycles   = 0;

	rx_mode_t   rx_mode  = RX_OPEN;
	logic [4:0] rx_phase = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one 80-round pass over blk_buf into chain_h
	function automatic void sha1_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16)
				w[r%16] = rotl32(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1sh_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1sh_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K3;
			end
			t = rotl32(a, 5) + f + e + k + w[r%16];
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void hasher_clear();
		for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++)
			chain_h[i] = H_INIT[i];
		msg_len = '0;
	endfunction

	// advance the predicted hasher by one accepted beat; closed marks a digest
	function automatic void hash_beat(input logic [7:0] data, input logic bv,
			input logic lst, output bit closed, output logic [159:0] dig);
		logic [63:0] bit_len;
		int          pos;
		closed = 1'b0;
		dig    = '0;
		if (bv) begin
			blk_buf[msg_len[5:0]] = data;
			msg_len += 64'd1;
			if (msg_len[5:0] == 6'd0)
				sha1_compress();
		end
		if (!lst)
			return;
		bit_len = msg_len << 3;
		pos = int'(msg_len[5:0]);
		blk_buf[pos] = sha1sh_pkg::PAD_BYTE;
		pos++;
		// no room left for the length, so pad out and compress an extra block
		if (pos > 56) begin
			while (pos < 64)
				blk_buf[pos++] = 8'h00;
			sha1_compress();
			pos = 0;
		end
		while (pos < 56)
			blk_buf[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk_buf[56+i] = bit_len[63-8*i -: 8];
		sha1_compress();
		dig    = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
		closed = 1'b1;
		hasher_clear();
	endfunction

	function automatic void queue_digest(input logic [159:0] dig);
		digest_beat_t b;
		for (int i = 0; i < sha1sh_pkg::NUM_WORDS; i++) begin
			b.word = dig[159-32*i -: 32];
			b.idx  = 3'(i);
			b.last = (i == sha1sh_pkg::NUM_WORDS - 1);
			expected_digest_q.push_back(b);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on digest beat %0d: %s got %h want %h",
			$time, words_checked, what, got, want);
		mismatch_count++;
	endtask

	// present one beat, hold it until taken, then predict; valid stays high
	// across a burst and drops only for a gap
	task automatic send_beat(input logic [7:0] data, input logic bv, input logic lst,
			input logic known, input logic [159:0] typed);
		bit           closed;
		logic [159:0] dig;
		if (burst_left == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		burst_left--;
		msg_ch.valid      <= 1'b1;
		msg_ch.data_byte  <= data;
		msg_ch.byte_valid <= bv;
		msg_ch.last       <= lst;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		hash_beat(data, bv, lst, closed, dig);
		if (closed) begin
			queue_digest(known ? typed : dig);
			n_messages++;
		end
		if (bv || lst)
			items_sent++;
		if (bv)
			n_bytes++;
	endtask

	// a whole random message, closed either on its final byte or by a
	// closing-only beat; stray idle beats are scattered through it
	task automatic send_message(input int len, input bit by_last);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			send_beat(8'($urandom), 1'b1, by_last && (i == len - 1), 1'b0, '0);
		end
		if (!by_last || len == 0)
			send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
		if (len > longest_msg)
			longest_msg = len;
	endtask

	// receiver ready pattern, switching mode each time rx_phase wraps
	always @(posedge clk) begin
		if (rx_phase == 5'd31)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		rx_phase <= rx_phase + 5'd1;
		case (rx_mode)
			RX_OPEN:   dig_ch.ready <= 1'b1;
			RX_COIN:   dig_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: dig_ch.ready <= (rx_phase[1:0] == 2'd0);
			default:   dig_ch.ready <= (rx_phase >= 5'd24);
		endcase
	end

	// digest beat checker
	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			if (expected_digest_q.size() == 0) begin
				report_mismatch("digest_word, none expected", dig_ch.digest_word, '0);
			end else begin
				want = expected_digest_q.pop_front();
				if (dig_ch.digest_word !== want.word)
					report_mismatch("digest_word", dig_ch.digest_word, want.word);
				if (dig_ch.word_index !== want.idx)
					report_mismatch("word_index", 32'(dig_ch.word_index), 32'(want.idx));
				if (dig_ch.last_word !== want.last)
					report_mismatch("last_word", 32'(dig_ch.last_word), 32'(want.last));
				words_checked++;
			end
		end
	end

	// watchdog on cycles with no beat taken on either channel
	always @(posedge clk) begin
		if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] no beat for %0d cycles, %0d digest beats outstanding",
				$time, STALL_LIMIT, expected_digest_q.size());
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int  len;
		int  pick;
		arst_n            <= 1'b0;
		msg_ch.valid      <= 1'b0;
		msg_ch.data_byte  <= 8'h00;
		msg_ch.byte_valid <= 1'b0;
		msg_ch.last       <= 1'b0;
		hasher_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[i])
			send_beat(DIR_TABLE[i].data, DIR_TABLE[i].bv, DIR_TABLE[i].lst,
				DIR_TABLE[i].known, DIR_TABLE[i].digest);

		// mostly short messages, some near the one-block padding edges,
		// a few long enough to cross two or more blocks
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				len = $urandom_range(0, 12);
			else if (pick < 18)
				len = $urandom_range(52, 66);
			else
				len = $urandom_range(100, 135);
			send_message(len, 1'($urandom_range(0, 1)));
		end

		msg_ch.valid <= 1'b0;
		while (expected_digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d messages, %0d message bytes, longest random one %0d bytes",
			n_messages, n_bytes, longest_msg);
		$display("checked %0d digest beats, %0d mismatches", words_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sha1_stream_hasher.f
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_if.sv
hw/rtl/sha1sh_ram.sv
hw/rtl/sha1sh_round.sv
hw/rtl/sha1_stream_hasher.sv
tb/sha1_stream_hasher_tb.sv
